@@ rtl/svpf_pkg.sv @@
// Shared types and constants for the stepper valve position follower.
// No dependencies; every other file imports this package.
`default_nettype none

package svpf_pkg;

    localparam int TIME_WIDTH      = 32;
    localparam int POSITION_WIDTH  = 8;
    localparam int CFG_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CMP_WIDTH       = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

    localparam int S_FIELD_BITS = TIME_WIDTH + POSITION_WIDTH;
    localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = POSITION_WIDTH + 2 + 2 + 1;
    localparam int M_TDATA_W    = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic [CFG_WIDTH-1:0] STEP_INTERVAL_RESET = CFG_WIDTH'(781);
    localparam logic [CFG_WIDTH-1:0] HOLD_DELAY_RESET    = CFG_WIDTH'(1000000);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_INTERVAL = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_DELAY    = CFG_INDEX_WIDTH'(1);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HOLD   = 2'd1,
        MODE_NORMAL = 2'd2,
        MODE_ACCEL  = 2'd3
    } drive_mode_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] step_interval_us;
        logic [CFG_WIDTH-1:0] hold_delay_us;
    } cfg_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]     now_us;
        logic [POSITION_WIDTH-1:0] target_position;
    } item_t;

    typedef struct packed {
        logic                      updated;
        drive_mode_t               drive_mode;
        logic [1:0]                coil_phase;
        logic [POSITION_WIDTH-1:0] position;
    } result_t;

    typedef struct packed {
        logic        holding;
        drive_mode_t mode;
        logic        at_origin;
    } core_status_t;

endpackage

`default_nettype wire

@@ rtl/svpf_cfg_regs.sv @@
// Configuration register file for the stepper valve position follower.
// Depends on svpf_pkg for the register index codes and the cfg_t struct.
`default_nettype none

module svpf_cfg_regs
    import svpf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_STEP_INTERVAL: cfg_next.step_interval_us = cfg_data;
                CFG_HOLD_DELAY:    cfg_next.hold_delay_us    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval_us <= STEP_INTERVAL_RESET;
            cfg_reg.hold_delay_us    <= HOLD_DELAY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/svpf_step_core.sv @@
// Position, phase and drive-mode state with the combinational step decision.
// Depends on svpf_pkg for the item, result, config and status types.
`default_nettype none

module svpf_step_core
    import svpf_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t   result,
    output core_status_t status
);

    logic [POSITION_WIDTH-1:0] position_reg, position_next;
    logic [1:0]                phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]     last_update_reg, last_update_next;
    logic [TIME_WIDTH-1:0]     last_move_reg, last_move_next;
    logic                      holding_reg, holding_next;
    drive_mode_t               mode_reg, mode_next;

    logic [TIME_WIDTH-1:0] since_update;
    logic [TIME_WIDTH-1:0] since_move;
    logic                  due;
    logic                  hold_due;

    assign since_update = item.now_us - last_update_reg;
    assign since_move   = item.now_us - last_move_reg;
    assign due      = CMP_WIDTH'(since_update) > CMP_WIDTH'(cfg.step_interval_us);
    assign hold_due = CMP_WIDTH'(since_move) > CMP_WIDTH'(cfg.hold_delay_us);

    always_comb begin
        position_next    = position_reg;
        phase_next       = phase_reg;
        last_update_next = last_update_reg;
        last_move_next   = last_move_reg;
        holding_next     = holding_reg;
        mode_next        = mode_reg;
        if (due) begin
            last_update_next = item.now_us;
            if (position_reg != item.target_position) begin
                mode_next      = MODE_ACCEL;
                last_move_next = item.now_us;
                holding_next   = 1'b0;
                if (position_reg < item.target_position) begin
                    position_next = position_reg + POSITION_WIDTH'(1);
                    phase_next    = phase_reg + 2'd1;
                end else begin
                    position_next = position_reg - POSITION_WIDTH'(1);
                    phase_next    = phase_reg - 2'd1;
                end
            end else if (holding_reg) begin
                mode_next = MODE_HOLD;
            end else if (hold_due) begin
                mode_next    = MODE_HOLD;
                holding_next = 1'b1;
            end else begin
                mode_next = MODE_NORMAL;
            end
        end
    end

    assign result.position   = position_next;
    assign result.coil_phase = phase_next;
    assign result.drive_mode = mode_next;
    assign result.updated    = due;

    assign status.holding   = holding_reg;
    assign status.mode      = mode_reg;
    assign status.at_origin = (position_reg == '0) && (phase_reg == 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= '0;
            phase_reg       <= '0;
            last_update_reg <= '0;
            last_move_reg   <= '0;
            holding_reg     <= 1'b0;
            mode_reg        <= MODE_IDLE;
        end else if (fire) begin
            position_reg    <= position_next;
            phase_reg       <= phase_next;
            last_update_reg <= last_update_next;
            last_move_reg   <= last_move_next;
            holding_reg     <= holding_next;
            mode_reg        <= mode_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/stepper_valve_position_follower.sv @@
// Top level of the stepper valve position follower: stream ports, input and
// result registers. Depends on svpf_pkg, svpf_cfg_regs and svpf_step_core.
//
// Usage: each transfer on the s_ channel carries a microsecond timestamp and a
// target position. When more than step_interval_us has passed since the last
// update, the position moves one step toward the target and the coil phase
// follows; at target the drive falls from normal to hold current once more
// than hold_delay_us has passed since the last move. Every input transfer
// yields exactly one result transfer on the m_ channel.
// The item passes from the input register through the result register, which
// drives m_tvalid; while the receiver is ready, one item is taken per cycle,
// since the whole update is a single pass of compare and increment logic
// between the input register and the result register.
// The cfg_ channel writes step_interval_us (index 0) and hold_delay_us
// (index 1) and is always ready; other indexes are ignored.
// Reset (aresetn low, synchronous) empties both registers, zeroes the state
// with the drive idle and restores the register defaults. When the receiver
// stalls, the result register holds and the input register still takes one
// more item before s_tready falls.
`default_nettype none

module stepper_valve_position_follower
    import svpf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // now_us, target_position
    input  wire logic [S_TDATA_W-1:0]       s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // position, coil_phase, drive_mode, updated
    output logic [M_TDATA_W-1:0]            m_tdata,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

    cfg_t         cfg;
    item_t        item_reg;
    logic         in_valid_reg;
    result_t      result_comb;
    result_t      result_reg;
    logic         out_valid_reg;
    core_status_t status;
    logic         advance;
    logic         fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg);

    svpf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svpf_step_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result_comb),
        .status  (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.now_us          <= s_tdata[TIME_WIDTH-1:0];
            item_reg.target_position <= s_tdata[S_FIELD_BITS-1:TIME_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_comb;
        end
    end

    // Holding is set only together with hold current and cleared by every move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.holding |-> (status.mode == MODE_HOLD))
        else $error("holding flag set without hold current");

    // The drive stays idle only until the first update, so an idle drive is still at home.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (status.mode == MODE_IDLE) |-> status.at_origin)
        else $error("idle drive with a moved position or phase");

    // Input backpressure arises only from a full pipe behind a stalled receiver.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a downstream stall");

    // A step taken in the core shows up as a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("result lost after a core update");

endmodule

`default_nettype wire

@@ verif/stepper_valve_position_follower_tb.sv @@
// Self-checking testbench for the stepper valve position follower.
// Depends on svpf_pkg and the stepper_valve_position_follower RTL only.
`timescale 1ns / 1ps

module stepper_valve_position_follower_tb;
    import svpf_pkg::*;

    localparam int          CLK_HALF    = 10;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          HOLD_OFF    = 300;

    // Indexes past the register file; writes to them must change nothing.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = CFG_INDEX_WIDTH'(3);

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_W-1:0]       s_tdata   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]       m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data  = '0;

    stepper_valve_position_follower DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Predicted follower state and register copies.
    logic [CFG_WIDTH-1:0]      step_gap_us   = STEP_INTERVAL_RESET;
    logic [CFG_WIDTH-1:0]      settle_us     = HOLD_DELAY_RESET;
    logic [POSITION_WIDTH-1:0] valve_pos     = '0;
    logic [1:0]                coil_ph       = '0;
    logic [TIME_WIDTH-1:0]     last_step_us  = '0;
    logic [TIME_WIDTH-1:0]     last_move_us  = '0;
    logic                      in_hold       = 1'b0;
    drive_mode_t               mode_now      = MODE_IDLE;

    result_t     expected_readings[$];
    int unsigned mismatches     = 0;
    int unsigned items_sent     = 0;
    int unsigned readings_seen  = 0;
    int unsigned reg_writes     = 0;
    int unsigned cycle_count    = 0;
    int unsigned rx_hold_req    = 0;
    int unsigned rx_hold_left   = 0;
    logic        no_idle        = 1'b0;
    logic [TIME_WIDTH-1:0] clock_us = '0;

    function automatic result_t follow_target(input logic [TIME_WIDTH-1:0] now_us,
                                              input logic [POSITION_WIDTH-1:0] aim);
        logic [TIME_WIDTH-1:0] since_step;
        logic [TIME_WIDTH-1:0] since_move;
        result_t r;
        since_step = now_us - last_step_us;
        since_move = now_us - last_move_us;
        r.updated  = 1'b0;
        if (since_step > step_gap_us) begin
            r.updated    = 1'b1;
            last_step_us = now_us;
            if (valve_pos != aim) begin
                mode_now = MODE_ACCEL;
                if (valve_pos < aim) begin
                    valve_pos = valve_pos + POSITION_WIDTH'(1);
                    coil_ph   = coil_ph + 2'd1;
                end else begin
                    valve_pos = valve_pos - POSITION_WIDTH'(1);
                    coil_ph   = coil_ph - 2'd1;
                end
                last_move_us = now_us;
                in_hold      = 1'b0;
            end else if (in_hold) begin
                mode_now = MODE_HOLD;
            end else if (since_move > settle_us) begin
                mode_now = MODE_HOLD;
                in_hold  = 1'b1;
            end else begin
                mode_now = MODE_NORMAL;
            end
        end
        r.position   = valve_pos;
        r.coil_phase = coil_ph;
        r.drive_mode = mode_now;
        return r;
    endfunction

    task automatic send_item(input logic [TIME_WIDTH-1:0] now_us,
                             input logic [POSITION_WIDTH-1:0] aim);
        while (!no_idle && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({aim, now_us});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_readings.push_back(follow_target(now_us, aim));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_STEP_INTERVAL) step_gap_us = value;
        else if (idx == CFG_HOLD_DELAY) settle_us = value;
        reg_writes++;
    endtask

    // Receiver: random stalls, plus a counted hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    always @(posedge aclk) begin : check_port
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[M_FIELD_BITS-1:0]);
            readings_seen++;
            if (expected_readings.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result pos=%0d phase=%0d mode=%0d upd=%0b",
                             $realtime, got.position, got.coil_phase, got.drive_mode,
                             got.updated);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                if (got !== want || m_tdata[M_TDATA_W-1:M_FIELD_BITS] !== '0) begin
                    if (mismatches < 10) begin
                        $write("%0t: result %0d mismatch: pos %0d/%0d phase %0d/%0d ",
                               $realtime, readings_seen, want.position, got.position,
                               want.coil_phase, got.coil_phase);
                        $display("mode %0d/%0d upd %0b/%0b pad %0h (expected/actual)",
                                 want.drive_mode, got.drive_mode, want.updated,
                                 got.updated, m_tdata[M_TDATA_W-1:M_FIELD_BITS]);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Default registers: first update, stepping both ways, hold entry and timestamp wrap.
    task automatic test_reset_defaults();
        send_item(32'd0, 8'd0);
        send_item(32'd781, 8'd0);
        send_item(32'd782, 8'd0);
        send_item(32'd2000, 8'd255);
        send_item(32'd2500, 8'd255);
        send_item(32'd3000, 8'd255);
        send_item(32'd4000, 8'd1);
        send_item(32'd5000, 8'd0);
        send_item(32'd6000, 8'd0);
        send_item(32'd1005000, 8'd0);
        send_item(32'd1006001, 8'd0);
        send_item(32'd1007000, 8'd0);
        send_item(32'hFFFF_FF00, 8'd3);
        send_item(32'hFFFF_FFFF, 8'd3);
        send_item(32'h0000_0200, 8'd3);
        send_item(32'h0000_0210, 8'd3);
        send_item(32'h0000_0100, 8'd3);
        send_item(32'h0000_0100, 8'd0);
    endtask

    // Register extremes and writes to unused indexes.
    task automatic test_register_extremes();
        write_reg(CFG_STEP_INTERVAL, '0);
        write_reg(CFG_HOLD_DELAY, '0);
        send_item(32'd100, 8'd5);
        send_item(32'd100, 8'd5);
        send_item(32'd101, 8'd5);
        send_item(32'd102, 8'd4);
        send_item(32'd103, 8'd4);
        send_item(32'd104, 8'd4);
        write_reg(CFG_SPARE_LO, $urandom());
        write_reg(CFG_SPARE_HI, $urandom());
        send_item(32'd105, 8'd4);
        write_reg(CFG_STEP_INTERVAL, '1);
        write_reg(CFG_HOLD_DELAY, '1);
        repeat (4) send_item($urandom(), POSITION_WIDTH'($urandom()));
        write_reg(CFG_STEP_INTERVAL, '0);
        send_item(32'd200, 8'd3);
        send_item(32'd201, 8'd3);
        send_item(32'hFFFF_FFFF, 8'd3);
        clock_us = 32'hFFFF_FFFF;
    endtask

    // End-to-end travel to both position limits with no idling on either side.
    task automatic test_full_travel();
        write_reg(CFG_STEP_INTERVAL, '0);
        write_reg(CFG_HOLD_DELAY, CFG_WIDTH'(100));
        no_idle = 1'b1;
        repeat (260) begin
            clock_us = clock_us + $urandom_range(1, 50);
            send_item(clock_us, 8'd255);
        end
        repeat (260) begin
            clock_us = clock_us + $urandom_range(1, 50);
            send_item(clock_us, 8'd0);
        end
        no_idle = 1'b0;
    endtask

    // Long receiver hold-off while items keep coming, so the input side stalls.
    task automatic test_output_hold_off();
        write_reg(CFG_STEP_INTERVAL, CFG_WIDTH'(10));
        rx_hold_req = HOLD_OFF;
        repeat (40) begin
            clock_us = clock_us + $urandom_range(5, 30);
            send_item(clock_us, POSITION_WIDTH'($urandom_range(0, 8)));
        end
    endtask

    task automatic test_random_following();
        logic [POSITION_WIDTH-1:0] aim;
        int                        v;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 4))
                0: write_reg(CFG_STEP_INTERVAL, '0);
                1: write_reg(CFG_STEP_INTERVAL, $urandom_range(1, 100));
                2: write_reg(CFG_STEP_INTERVAL, STEP_INTERVAL_RESET);
                3: write_reg(CFG_STEP_INTERVAL, $urandom_range(0, 2000));
                default: write_reg(CFG_STEP_INTERVAL, $urandom());
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(CFG_HOLD_DELAY, '0);
                1: write_reg(CFG_HOLD_DELAY, '1);
                2: write_reg(CFG_HOLD_DELAY, $urandom());
                default: write_reg(CFG_HOLD_DELAY, $urandom_range(0, 3000));
            endcase
            aim = valve_pos;
            repeat (140) begin
                if ($urandom_range(0, 24) == 0) begin
                    case ($urandom_range(0, 3))
                        0: aim = POSITION_WIDTH'($urandom());
                        3: aim = valve_pos;
                        default: begin
                            v = int'(valve_pos) + int'($urandom_range(0, 12)) - 6;
                            if (v < 0) v = 0;
                            if (v > 255) v = 255;
                            aim = POSITION_WIDTH'(v);
                        end
                    endcase
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        clock_us = clock_us + step_gap_us + $urandom_range(0, 4) - 2;
                    6, 7: clock_us = clock_us + $urandom_range(0, 2000);
                    8: clock_us = $urandom();
                    default: ;
                endcase
                if ($urandom_range(0, 9) == 0)
                    send_item(clock_us, POSITION_WIDTH'($urandom()));
                else
                    send_item(clock_us, aim);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_full_travel();
        test_output_hold_off();
        test_random_following();
        wait_drained();
        $display("Sent %0d timestamp/target items and checked %0d results across %0d",
                 items_sent, readings_seen, reg_writes);
        $display("register writes: both position limits, hold entry, wrap and a stalled output.");
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_readings.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/svpf_pkg.sv
rtl/svpf_cfg_regs.sv
rtl/svpf_step_core.sv
rtl/stepper_valve_position_follower.sv
verif/stepper_valve_position_follower_tb.sv
